### rtl/core/e2q_pkg.sv
`default_nettype none
package e2q_pkg;
  localparam int AngleWidth  = 16;
  localparam int ResultWidth = 16;
  localparam int CordicSteps = 16;
  localparam int Qf          = 30;
  localparam int AngleFrac   = AngleWidth - 3;
  localparam int ResFrac     = ResultWidth - 2;
  // Q30 working width: |x|,|y| <= ~1.65, |z| < 2
  localparam int CW          = 33;

  typedef logic signed [AngleWidth-1:0]  angle_t;
  typedef logic signed [ResultWidth-1:0] result_t;
  typedef logic signed [CW-1:0]          cval_t;
  typedef logic [$clog2(CordicSteps)-1:0] step_t;

  // pi in Q30, rounded to the input format
  localparam longint PiQ30 = 64'sd3373259426;
  localparam angle_t PiIn =
    angle_t'((PiQ30 + (64'sd1 <<< (Qf - AngleFrac - 1))) >>> (Qf - AngleFrac));
  localparam logic signed [CW-1:0] CordicGain = 33'sd652032874;

  typedef struct packed {
    cval_t s;
    cval_t c;
  } sincos_t;

  function automatic cval_t atan_q30(input int i);
    cval_t r;
    r = '0;
    unique case (i)
      0: r = 33'sd843314856;  1: r = 33'sd497837829;
      2: r = 33'sd263043836;  3: r = 33'sd133525158;
      4: r = 33'sd66967392;   5: r = 33'sd33539419;
      6: r = 33'sd16775850;   7: r = 33'sd8388437;
      8: r = 33'sd4194282;    9: r = 33'sd2097149;
      10: r = 33'sd1048575;   11: r = 33'sd524287;
      12: r = 33'sd262143;    13: r = 33'sd131071;
      14: r = 33'sd65535;     15: r = 33'sd32767;
      16: r = 33'sd16383;     17: r = 33'sd8191;
      18: r = 33'sd4095;      19: r = 33'sd2047;
      20: r = 33'sd1023;      21: r = 33'sd511;
      22: r = 33'sd255;       23: r = 33'sd127;
      24: r = 33'sd63;        25: r = 33'sd31;
      26: r = 33'sd15;        27: r = 33'sd7;
      28: r = 33'sd3;         29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q30 product, rounded half up
  function automatic cval_t qmul(input cval_t a, input cval_t b);
    logic signed [2*CW-1:0] p;
    p = 66'(a) * 66'(b) + (66'sd1 <<< (Qf - 1));
    return cval_t'(p >>> Qf);
  endfunction
endpackage
`default_nettype wire

### rtl/core/e2q_if.sv
`default_nettype none
interface e2q_in_if;
  logic valid;
  logic ready;
  e2q_pkg::angle_t angle_x;
  e2q_pkg::angle_t angle_y;
  e2q_pkg::angle_t angle_z;
  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface e2q_out_if;
  logic valid;
  logic ready;
  e2q_pkg::result_t quat_x;
  e2q_pkg::result_t quat_y;
  e2q_pkg::result_t quat_z;
  e2q_pkg::result_t quat_w;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

### rtl/core/euler_angles_to_quaternion.sv
`default_nettype none
// Channel  Dir  Payload
// in_if    in   angle_x, angle_y, angle_z (Q3.13 rad)
// out_if   out  quat_x, quat_y, quat_z, quat_w (Q2.14)
// Pipeline: 1 input clamp/seed stage, 16 CORDIC steps, 3 product/round stages, 1 output register.
// One transfer per cycle; each stage holds while the stage after it is full and stalled.
// Reset clears only the valid bits; data registers are not reset.
// A stall loses nothing: in_if.ready falls only when the whole pipe is full.
module euler_angles_to_quaternion (
  input wire clk_i,
  input wire rst_ni,
  e2q_in_if.sink    in_if,
  e2q_out_if.source out_if
);
  import e2q_pkg::*;
  localparam int NS = CordicSteps + 5;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  // stage i advances when it is empty or the one after it moves
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || out_if.ready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !vld_q[i] || en[i+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_if.valid;
      for (int i = 1; i < NS; i++) if (en[i]) vld_q[i] <= vld_q[i-1];
    end
  end

  assign in_if.ready = en[0];

  // clamp, scale to Q30 half angle, seed
  cval_t [2:0] x0_q, y0_q, z0_q;
  angle_t [2:0] ang;
  assign ang[0] = in_if.angle_x;
  assign ang[1] = in_if.angle_y;
  assign ang[2] = in_if.angle_z;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        angle_t c;
        c = ang[a];
        if (c > PiIn) c = PiIn;
        if (c < -PiIn) c = -PiIn;
        x0_q[a] <= CordicGain;
        y0_q[a] <= '0;
        z0_q[a] <= CW'(c) <<< (Qf - 1 - AngleFrac);
      end
    end
  end

  cval_t [CordicSteps:0][2:0] xs, ys, zs;
  assign xs[0] = x0_q;
  assign ys[0] = y0_q;
  assign zs[0] = z0_q;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cordic
    e2q_cordic_stage u_stage (
      .clk_i  (clk_i),
      .en_i   (en[g+1]),
      .step_i (step_t'(g)),
      .x_i    (xs[g]),
      .y_i    (ys[g]),
      .z_i    (zs[g]),
      .x_o    (xs[g+1]),
      .y_o    (ys[g+1]),
      .z_o    (zs[g+1])
    );
  end

  sincos_t [2:0] sc;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sc[a].s = ys[CordicSteps][a];
      sc[a].c = xs[CordicSteps][a];
    end
  end

  result_t [3:0] quat;
  e2q_combine u_combine (
    .clk_i  (clk_i),
    .en_i   (en[CordicSteps+3:CordicSteps+1]),
    .sc_i   (sc),
    .quat_o (quat)
  );

  // output register
  result_t [3:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en[NS-1]) out_q <= quat;
  end

  assign out_if.valid  = vld_q[NS-1];
  assign out_if.quat_x = out_q[0];
  assign out_if.quat_y = out_q[1];
  assign out_if.quat_z = out_q[2];
  assign out_if.quat_w = out_q[3];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_q))
    else $error("output changed under stall");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> vld_q[0] && out_if.valid && !out_if.ready)
    else $error("input stalled with room in pipe");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_q[3] <= result_t'(1 <<< ResFrac)
                  && out_q[3] >= -result_t'(1 <<< ResFrac))
    else $error("w out of range");
endmodule
`default_nettype wire

### rtl/core/e2q_cordic_stage.sv
`default_nettype none
// One CORDIC micro-rotation for three angles, registered.
// step_i is tied to the stage index.
module e2q_cordic_stage (
  input  wire                  clk_i,
  input  wire                  en_i,
  input  e2q_pkg::step_t       step_i,
  input  e2q_pkg::cval_t [2:0] x_i,
  input  e2q_pkg::cval_t [2:0] y_i,
  input  e2q_pkg::cval_t [2:0] z_i,
  output e2q_pkg::cval_t [2:0] x_o,
  output e2q_pkg::cval_t [2:0] y_o,
  output e2q_pkg::cval_t [2:0] z_o
);
  import e2q_pkg::*;
  cval_t [2:0] x_d, y_d, z_d, x_q, y_q, z_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (!z_i[a][CW-1]) begin
        x_d[a] = x_i[a] - (y_i[a] >>> step_i);
        y_d[a] = y_i[a] + (x_i[a] >>> step_i);
        z_d[a] = z_i[a] - atan_q30(int'(step_i));
      end else begin
        x_d[a] = x_i[a] + (y_i[a] >>> step_i);
        y_d[a] = y_i[a] - (x_i[a] >>> step_i);
        z_d[a] = z_i[a] + atan_q30(int'(step_i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
endmodule
`default_nettype wire

### rtl/core/e2q_combine.sv
`default_nettype none
// Triple products and final rounding, three register stages.
module e2q_combine (
  input  wire                    clk_i,
  input  wire  [2:0]             en_i,
  input  e2q_pkg::sincos_t [2:0] sc_i,
  output e2q_pkg::result_t [3:0] quat_o
);
  import e2q_pkg::*;
  localparam int ResShift = Qf - ResFrac;
  cval_t sx_q, cx_q;
  cval_t cycz_q, sysz_q, sycz_q, cysz_q;
  cval_t [7:0] t_q;
  result_t [3:0] q_q;
  cval_t [3:0] sum;

  // half an output LSB is zero when no bits are dropped
  function automatic result_t to_res(input cval_t v);
    logic signed [CW:0] r;
    r = (CW+1)'(v) + (((CW+1)'(1) <<< ResShift) >>> 1);
    r = r >>> ResShift;
    if (r > (CW+1)'(1 <<< ResFrac)) r = (CW+1)'(1 <<< ResFrac);
    if (r < -(CW+1)'(1 <<< ResFrac)) r = -(CW+1)'(1 <<< ResFrac);
    return result_t'(r);
  endfunction

  // first products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sx_q   <= sc_i[0].s;
      cx_q   <= sc_i[0].c;
      cycz_q <= qmul(sc_i[1].c, sc_i[2].c);
      sysz_q <= qmul(sc_i[1].s, sc_i[2].s);
      sycz_q <= qmul(sc_i[1].s, sc_i[2].c);
      cysz_q <= qmul(sc_i[1].c, sc_i[2].s);
    end
  end

  // second products
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      t_q[0] <= qmul(sx_q, cycz_q);
      t_q[1] <= qmul(cx_q, sysz_q);
      t_q[2] <= qmul(cx_q, sycz_q);
      t_q[3] <= qmul(sx_q, cysz_q);
      t_q[4] <= qmul(cx_q, cysz_q);
      t_q[5] <= qmul(sx_q, sycz_q);
      t_q[6] <= qmul(cx_q, cycz_q);
      t_q[7] <= qmul(sx_q, sysz_q);
    end
  end

  assign sum[0] = t_q[0] - t_q[1];
  assign sum[1] = t_q[2] + t_q[3];
  assign sum[2] = t_q[4] - t_q[5];
  assign sum[3] = t_q[6] + t_q[7];

  // round and saturate
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int k = 0; k < 4; k++) q_q[k] <= to_res(sum[k]);
    end
  end

  assign quat_o = q_q;
endmodule
`default_nettype wire

### tb/sv/euler_angles_to_quaternion_tb.sv
module euler_angles_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import e2q_pkg::*;

  typedef struct packed {
    result_t qx;
    result_t qy;
    result_t qz;
    result_t qw;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  e2q_in_if in_ch ();
  e2q_out_if out_ch ();

  euler_angles_to_quaternion dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch.sink),
    .out_if(out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  quat_t quat_queue[$];
  int    mismatches = 0;
  bit    idle_on = 1'b1;
  localparam logic signed [15:0] PiAngle = 16'sd25736;

  // atan(2^-i) in Q30, floor
  function automatic longint atan_entry(input int i);
    longint tbl[32] = '{843314856, 497837829, 263043836, 133525158, 66967392, 33539419,
                        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
                        262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047,
                        1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0};
    return tbl[i];
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // sine and cosine of the half angle, Q30
  task automatic half_sincos(input angle_t ang, output longint s, output longint c);
    longint a, x, y, z, xs, ys;
    a = ang;
    if (a > 25736) a = 25736;
    if (a < -25736) a = -25736;
    z = a <<< 16;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_entry(i);
      end else begin
        x += ys; y -= xs; z += atan_entry(i);
      end
    end
    s = y;
    c = x;
  endtask

  function automatic result_t round_sat(input longint v);
    v = (v + (64'sd1 <<< 15)) >>> 16;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return result_t'(v);
  endfunction

  task automatic predict_quat(input angle_t ax, input angle_t ay, input angle_t az);
    longint sx, cx, sy, cy, sz, cz, cycz, sysz, sycz, cysz;
    quat_t q;
    half_sincos(ax, sx, cx);
    half_sincos(ay, sy, cy);
    half_sincos(az, sz, cz);
    cycz = q30_mul(cy, cz);
    sysz = q30_mul(sy, sz);
    sycz = q30_mul(sy, cz);
    cysz = q30_mul(cy, sz);
    q.qx = round_sat(q30_mul(sx, cycz) - q30_mul(cx, sysz));
    q.qy = round_sat(q30_mul(cx, sycz) + q30_mul(sx, cysz));
    q.qz = round_sat(q30_mul(cx, cysz) - q30_mul(sx, sycz));
    q.qw = round_sat(q30_mul(cx, cycz) + q30_mul(sx, sysz));
    quat_queue.push_back(q);
  endtask

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH %s: got %0d, want %0d", what, got, want);
  endtask

  // drive one transfer, with an optional random gap first
  task automatic send_angles(input angle_t ax, input angle_t ay, input angle_t az);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.angle_x <= ax;
    in_ch.angle_y <= ay;
    in_ch.angle_z <= az;
    predict_quat(ax, ay, az);
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  function automatic angle_t rand_angle();
    case ($urandom_range(0, 5))
      0: return angle_t'($urandom);
      1: return angle_t'($urandom_range(0, 40) - 20 + 25736);
      2: return angle_t'(-25736 - 20 + $urandom_range(0, 40));
      default: return angle_t'($urandom_range(0, 51472) - 25736);
    endcase
  endfunction

  // sink side: random stalls, check each transfer
  initial begin
    quat_t q;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        if (quat_queue.size() == 0) begin
          report("unexpected transfer", 0, 0);
        end else begin
          q = quat_queue.pop_front();
          if (out_ch.quat_x !== q.qx) report("quat_x", out_ch.quat_x, q.qx);
          if (out_ch.quat_y !== q.qy) report("quat_y", out_ch.quat_y, q.qy);
          if (out_ch.quat_z !== q.qz) report("quat_z", out_ch.quat_z, q.qz);
          if (out_ch.quat_w !== q.qw) report("quat_w", out_ch.quat_w, q.qw);
        end
      end
    end
  end

  task automatic test_extremes();
    angle_t vals[9] = '{16'sh7FFF, 16'sh8000, PiAngle, -PiAngle, 16'sd0,
                        16'sd25737, -16'sd25737, 16'sd1, -16'sd1};
    foreach (vals[i]) send_angles(vals[i], vals[(i + 3) % 9], vals[(i + 6) % 9]);
    send_angles(16'sd12868, 16'sd12868, 16'sd12868);
    send_angles(-16'sd12868, 16'sd25736, 16'sd6434);
    send_angles(16'sh5555, 16'shAAAA, 16'sh7FFF);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic test_random(input int n);
    repeat (n) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  task automatic test_full_rate(input int n);
    idle_on = 1'b0;
    repeat (n) send_angles(rand_angle(), rand_angle(), rand_angle());
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.angle_x <= '0;
    in_ch.angle_y <= '0;
    in_ch.angle_z <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random(400);
    // hold off until the pipe is empty
    drain();
    test_random(300);
    test_full_rate(140);
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
